FILE: sv/fat12_pkg.sv
// ----------------------------------------------------------------------------
// FAT12 lookup package
// Shared constants, status codes and the classified word type.
// ----------------------------------------------------------------------------
package fat12_pkg;

  localparam int unsigned FatBytesDefault = 8192;
  localparam int unsigned DivSteps = 32;

  typedef enum logic [2:0] {
    StLinked = 3'd0,
    StRoot   = 3'd1,
    StEnd    = 3'd2,
    StBelow  = 3'd3,
    StRange  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CfgRoot    = 2'd0,
    CfgData    = 2'd1,
    CfgCluster = 2'd2
  } cfg_idx_e;

  localparam logic [11:0] EntryMask = 12'hFFF;
  localparam logic [11:0] EntryLow  = 12'h002;
  localparam logic [11:0] EntryHigh = 12'hFF0;
  localparam logic [31:0] QuotMax   = 32'hFFFF_FFFF;

  // A word as it leaves the front part.
  typedef struct packed {
    logic        is_load;
    logic [12:0] wr_idx;
    logic [7:0]  wr_byte;
    logic        is_data;
    logic [31:0] next_offset;
    status_e     status;
    logic [31:0] dividend;
  } cls_t;

endpackage

FILE: sv/fat12_next_cluster_lookup.sv
// A lookup result passes the front register, the queue and, in the back part, the
// input register, the 32 restoring divider stages and the index, table read, decode
// and output registers, all pipelined: one word per cycle unless the output stalls.
// Load words give no result; they travel the same pipeline and write the store in order.
// Reset clears all handshake state and sets the registers to 0, 0 and 512.
// The table store is not cleared by reset.
// ----------------------------------------------------------------------------
// FAT12 next cluster lookup
// Top level: configuration registers, front part, queue and back part.
// ----------------------------------------------------------------------------
module fat12_next_cluster_lookup #(
  parameter int unsigned FatBytes = fat12_pkg::FatBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: fat_byte_index[12:0], fat_byte[20:13], cluster_offset[52:21], zero pad
  input  logic [55:0] s_axis_tdata,
  // tuser: command
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: next_offset[31:0], raw_entry[43:32], status[46:44], zero pad
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] root_q, data_q;
  logic [16:0] clb_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      data_q <= '0;
      clb_q  <= 17'd512;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fat12_pkg::CfgRoot:    root_q <= cfg_data_i;
        fat12_pkg::CfgData:    data_q <= cfg_data_i;
        fat12_pkg::CfgCluster: clb_q  <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  logic             f_v, f_r, q_v, q_r;
  fat12_pkg::cls_t  f_c, q_c;
  logic [31:0]      nx;
  logic [11:0]      ent;
  logic [2:0]       st;

  fat12_front #(.FatBytes(FatBytes)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tuser), .byte_idx_i(s_axis_tdata[12:0]),
    .byte_val_i(s_axis_tdata[20:13]), .offset_i(s_axis_tdata[52:21]),
    .root_start_i(root_q), .data_start_i(data_q), .cluster_bytes_i(clb_q),
    .cls_valid_o(f_v), .cls_ready_i(f_r), .cls_o(f_c)
  );

  fat12_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(f_v), .in_ready_o(f_r), .in_i(f_c),
    .out_valid_o(q_v), .out_ready_i(q_r), .out_o(q_c)
  );

  fat12_back #(.FatBytes(FatBytes)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_v), .in_ready_o(q_r), .in_i(q_c),
    .data_start_i(data_q), .cluster_bytes_i(clb_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .next_offset_o(nx), .raw_entry_o(ent), .status_o(st)
  );

  assign m_axis_tdata = {1'b0, st, ent, nx};

endmodule

FILE: sv/fat12_front.sv
// ----------------------------------------------------------------------------
// FAT12 front part
// Accepts words, drops table writes past the store and classifies lookups.
// ----------------------------------------------------------------------------
module fat12_front #(
  parameter int unsigned FatBytes = fat12_pkg::FatBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [12:0]         byte_idx_i,
  input  logic [7:0]          byte_val_i,
  input  logic [31:0]         offset_i,
  input  logic [31:0]         root_start_i,
  input  logic [31:0]         data_start_i,
  input  logic [16:0]         cluster_bytes_i,
  output logic                cls_valid_o,
  input  logic                cls_ready_i,
  output fat12_pkg::cls_t     cls_o
);

  fat12_pkg::cls_t cls_d, cls_q;
  logic            valid_q;
  logic            take;
  logic            ld_ok;
  logic [32:0]     sum;

  assign in_ready_o = !valid_q || cls_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign ld_ok      = {4'd0, byte_idx_i} < 17'(FatBytes);
  assign sum        = {1'b0, offset_i} + {16'd0, cluster_bytes_i};

  always_comb begin
    cls_d = '0;
    cls_d.is_load  = !cmd_i;
    cls_d.wr_idx   = byte_idx_i;
    cls_d.wr_byte  = byte_val_i;
    cls_d.dividend = offset_i - data_start_i;
    if (offset_i >= data_start_i) begin
      cls_d.is_data = 1'b1;
      cls_d.status  = fat12_pkg::StLinked;
    end else if (offset_i < root_start_i) begin
      cls_d.status = fat12_pkg::StBelow;
    end else if (sum < {1'b0, data_start_i}) begin
      cls_d.status      = fat12_pkg::StRoot;
      cls_d.next_offset = sum[31:0];
    end else begin
      cls_d.status = fat12_pkg::StEnd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= take && (cmd_i || ld_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cls_q <= cls_d;
    end
  end

  assign cls_valid_o = valid_q;
  assign cls_o       = cls_q;

endmodule

FILE: sv/fat12_fifo.sv
// ----------------------------------------------------------------------------
// FAT12 word queue
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module fat12_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  fat12_pkg::cls_t in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fat12_pkg::cls_t out_o
);

  fat12_pkg::cls_t mem_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  logic            push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_o       = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_i;
    end
  end

endmodule

FILE: sv/fat12_back.sv
// ----------------------------------------------------------------------------
// FAT12 back part
// Pipelined divider, in-order table writes, table read and link computation.
// ----------------------------------------------------------------------------
module fat12_back #(
  parameter int unsigned FatBytes = fat12_pkg::FatBytesDefault,
  parameter int unsigned AddrW = $clog2(FatBytes)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fat12_pkg::cls_t  in_i,
  input  logic [31:0]      data_start_i,
  input  logic [16:0]      cluster_bytes_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      next_offset_o,
  output logic [11:0]      raw_entry_o,
  output logic [2:0]       status_o
);

  localparam int unsigned N = fat12_pkg::DivSteps;
  localparam int unsigned S = N + 5;

  logic               adv;
  logic [S-1:0]       vld_q;
  fat12_pkg::cls_t    in_m;
  fat12_pkg::cls_t    c_q  [N+1];
  logic [31:0]        rem_q [N+1];
  logic [31:0]        quo_q [N+1];

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    in_m         = in_i;
    in_m.is_load = in_i.is_load && in_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[S-2:0], in_valid_i && !in_i.is_load};
    end
  end

  // Restoring division, one quotient bit a stage, MSB first.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q[0]   <= in_m;
      rem_q[0] <= '0;
      quo_q[0] <= in_i.dividend;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_div
    logic [32:0] sh, df;
    assign sh = {rem_q[k], quo_q[k][31]};
    assign df = sh - {16'd0, cluster_bytes_i};
    always_ff @(posedge clk_i) begin
      if (adv) begin
        c_q[k+1] <= c_q[k];
        if (!df[32]) begin
          rem_q[k+1] <= df[31:0];
          quo_q[k+1] <= {quo_q[k][30:0], 1'b1};
        end else begin
          rem_q[k+1] <= sh[31:0];
          quo_q[k+1] <= {quo_q[k][30:0], 1'b0};
        end
      end
    end
  end

  // Index stage.
  logic [31:0]     n_d;
  logic [33:0]     idx_d;
  fat12_pkg::cls_t a_q;
  logic            odd_q, oor_q;
  logic [AddrW-1:0] ia_q, ib_q;

  assign n_d   = (cluster_bytes_i == '0 ? fat12_pkg::QuotMax : quo_q[N]) + 32'd2;
  assign idx_d = ({2'b0, n_d} + {1'b0, n_d, 1'b0}) >> 1;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q   <= c_q[N];
      odd_q <= n_d[0];
      oor_q <= (idx_d + 34'd1) >= 34'(FatBytes);
      ia_q  <= AddrW'(idx_d);
      ib_q  <= AddrW'(idx_d + 34'd1);
    end
  end

  // Table read stage.
  logic [7:0]      mem [FatBytes];
  logic [7:0]      lo_q, hi_q;
  fat12_pkg::cls_t b_q;
  logic            odd2_q, oor2_q;

  always_ff @(posedge clk_i) begin
    if (adv && a_q.is_load) begin
      mem[AddrW'(a_q.wr_idx)] <= a_q.wr_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo_q   <= mem[ia_q];
      hi_q   <= mem[ib_q];
      b_q    <= a_q;
      odd2_q <= odd_q;
      oor2_q <= oor_q;
    end
  end

  // Entry decode and link multiply.
  logic [15:0] raw;
  logic [11:0] dec_ent;
  logic [11:0] ent_d, ent_q;
  logic [28:0] prod_d, prod_q;
  logic [2:0]  st_d, st_q;
  logic [31:0] nx_d, nx_q;
  logic        lnk_d, lnk_q;

  assign raw     = {hi_q, lo_q};
  assign dec_ent = (odd2_q ? raw[15:4] : raw[11:0]) & fat12_pkg::EntryMask;

  always_comb begin
    lnk_d  = 1'b0;
    ent_d  = '0;
    nx_d   = b_q.next_offset;
    st_d   = b_q.status;
    prod_d = '0;
    if (b_q.is_data) begin
      nx_d = '0;
      if (oor2_q) begin
        st_d = fat12_pkg::StRange;
      end else begin
        ent_d = dec_ent;
        if (dec_ent >= fat12_pkg::EntryLow && dec_ent < fat12_pkg::EntryHigh) begin
          lnk_d  = 1'b1;
          st_d   = fat12_pkg::StLinked;
          prod_d = 29'(dec_ent - fat12_pkg::EntryLow) * 29'(cluster_bytes_i);
        end else begin
          st_d = fat12_pkg::StEnd;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lnk_q  <= lnk_d;
      ent_q  <= ent_d;
      nx_q   <= nx_d;
      st_q   <= st_d;
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      next_offset_o <= lnk_q ? data_start_i + {3'd0, prod_q} : nx_q;
      raw_entry_o   <= ent_q;
      status_o      <= st_q;
    end
  end

  assign out_valid_o = vld_q[S-1];

endmodule

FILE: test/tb_fat12_next_cluster_lookup.sv
// ----------------------------------------------------------------------------
// FAT12 next cluster lookup testbench
// Loads table bytes, runs lookups under several register settings, with random
// stalls on both streams but the last, and checks each result vs a predictor.
// ----------------------------------------------------------------------------
module tb_fat12_next_cluster_lookup;

  localparam int unsigned TblBytes = 8192;

  typedef struct packed {
    logic [31:0]        next_offset;
    logic [11:0]        raw_entry;
    fat12_pkg::status_e status;
  } lookup_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  logic [7:0]  table_mirror [TblBytes];
  bit          table_loaded [TblBytes];
  logic [31:0] root_reg;
  logic [31:0] data_reg;
  logic [16:0] clus_reg;
  lookup_res_t pending_results[$];
  int          n_errors = 0;
  int          stall_left = 0;
  bit          stall_on = 1'b1;

  fat12_next_cluster_lookup u_top (.*);

  always #2 clk_i = ~clk_i;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    n_errors++;
  endtask

  function automatic lookup_res_t predict_next(input logic [31:0] off);
    lookup_res_t r;
    logic [32:0] sum;
    logic [31:0] q, n;
    logic [33:0] idx;
    logic [15:0] pair;
    logic [11:0] ent;
    logic [47:0] lnk;
    r = '{32'd0, 12'd0, fat12_pkg::StLinked};
    if (off < data_reg) begin
      sum = {1'b0, off} + {16'd0, clus_reg};
      if (off < root_reg) r.status = fat12_pkg::StBelow;
      else if (sum < {1'b0, data_reg}) begin
        r.status = fat12_pkg::StRoot;
        r.next_offset = sum[31:0];
      end else r.status = fat12_pkg::StEnd;
      return r;
    end
    q = (clus_reg == 0) ? fat12_pkg::QuotMax : (off - data_reg) / {15'd0, clus_reg};
    n = q + 32'd2;
    idx = ({2'b0, n} * 34'd3) >> 1;
    if (idx + 34'd1 >= TblBytes) begin
      r.status = fat12_pkg::StRange;
      return r;
    end
    pair = {table_mirror[idx + 1], table_mirror[idx]};
    ent = n[0] ? pair[15:4] : pair[11:0];
    r.raw_entry = ent;
    if (ent >= fat12_pkg::EntryLow && ent < fat12_pkg::EntryHigh) begin
      lnk = {16'd0, data_reg} + 48'(ent - 12'd2) * 48'(clus_reg);
      r.next_offset = lnk[31:0];
    end else r.status = fat12_pkg::StEnd;
    return r;
  endfunction

  task automatic idle_gap();
    if (stall_on && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_word(input bit cmd, input logic [12:0] bidx, input logic [7:0] bval,
                           input logic [31:0] off);
    idle_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'd0, off, bval, bidx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd) pending_results.push_back(predict_next(off));
    else begin
      table_mirror[bidx] = bval;
      table_loaded[bidx] = 1'b1;
    end
  endtask

  task automatic load_byte(input int i, input logic [7:0] v);
    send_word(1'b0, 13'(i), v, $urandom);
  endtask

  // Only offsets whose table bytes are loaded, or that never read the table.
  function automatic bit offset_safe(input logic [31:0] off);
    logic [31:0] q, n;
    logic [33:0] idx;
    if (off < data_reg) return 1'b1;
    q = (clus_reg == 0) ? fat12_pkg::QuotMax : (off - data_reg) / {15'd0, clus_reg};
    n = q + 32'd2;
    idx = ({2'b0, n} * 34'd3) >> 1;
    if (idx + 34'd1 >= TblBytes) return 1'b1;
    return table_loaded[idx] && table_loaded[idx + 1];
  endfunction

  task automatic look_up(input logic [31:0] off);
    if (offset_safe(off)) send_word(1'b1, 13'($urandom), 8'($urandom), off);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  task automatic write_reg(input fat12_pkg::cfg_idx_e idx, input logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      fat12_pkg::CfgRoot: root_reg = v;
      fat12_pkg::CfgData: data_reg = v;
      default:            clus_reg = v[16:0];
    endcase
  endtask

  task automatic set_layout(input logic [31:0] r, input logic [31:0] d, input logic [16:0] c);
    drain();
    write_reg(fat12_pkg::CfgRoot, r);
    write_reg(fat12_pkg::CfgData, d);
    write_reg(fat12_pkg::CfgCluster, {15'd0, c});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic offset_for(input int unsigned clus, output logic [31:0] off);
    off = data_reg + clus * clus_reg + $urandom_range(clus_reg == 0 ? 0 : clus_reg - 1);
  endtask

  task automatic test_load_table();
    for (int i = 0; i < 192; i++) load_byte(i, 8'($urandom));
    load_byte(8190, 8'($urandom));
    load_byte(8191, 8'($urandom));
    load_byte(0, 8'h00);
    load_byte(1, 8'hFF);
    load_byte(2, 8'hFF);
    load_byte(3, 8'hF0);
    load_byte(4, 8'h2F);
    load_byte(5, 8'hFE);
    load_byte(6, 8'hF0);
    load_byte(7, 8'hFF);
  endtask

  task automatic test_directed();
    set_layout(32'h0000_4200, 32'h0000_5000, 17'd512);
    look_up(32'd0);
    look_up(32'h0000_41FF);
    look_up(32'h0000_4200);
    look_up(32'h0000_4E00);
    look_up(32'h0000_4E01);
    look_up(32'h0000_5000);
    look_up(32'h0000_5200);
    look_up(32'h0000_5400);
    look_up(32'h0000_5600);
    look_up(32'h0000_5800);
    look_up(32'hFFFF_FFFF);
    look_up(32'h0000_5000 + 32'd5459 * 512);
    look_up(32'h0000_5000 + 32'd5458 * 512);
    set_layout(32'h0000_9000, 32'h0000_1000, 17'd1);
    look_up(32'h0000_0800);
    look_up(32'h0000_1004);
    look_up(32'h0000_9100);
    set_layout(32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd65536);
    look_up(32'hFFFF_FFFE);
    look_up(32'hFFFF_FFFF);
    set_layout(32'd0, 32'd0, 17'd0);
    look_up(32'd0);
    look_up(32'h8000_0000);
    set_layout(32'hFFFF_0000, 32'hFFFF_FFFF, 17'd65536);
    look_up(32'hFFFF_FFF0);
  endtask

  task automatic test_random(input int count);
    logic [31:0] off;
    repeat (count) begin
      case ($urandom_range(9))
        0: load_byte($urandom_range(TblBytes - 1), 8'($urandom));
        1: look_up($urandom);
        2: look_up(root_reg + $urandom_range(2000));
        default: begin
          offset_for($urandom_range(120), off);
          look_up(off);
        end
      endcase
    end
  endtask

  task automatic test_settings();
    set_layout(32'h0000_2600, 32'h0000_4200, 17'd512);
    test_random(80);
    set_layout(32'h0000_1000, 32'h0000_0400, 17'd2048);
    test_random(70);
    set_layout($urandom, $urandom, 17'($urandom_range(65536, 1)));
    test_random(60);
    set_layout(32'd0, 32'h0001_0000, 17'd1);
    test_random(50);
    stall_on = 1'b0;
    set_layout(32'h0000_2600, 32'h0000_4200, 17'd65536);
    test_random(60);
  endtask

  always @(posedge clk_i) begin
    lookup_res_t exp_r;
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_on && $urandom_range(5) == 0) begin
      stall_left = $urandom_range(6);
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= 1'b1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report("unexpected word", m_axis_tdata[31:0], 32'd0);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata[31:0] != exp_r.next_offset)
          report("next_offset", m_axis_tdata[31:0], exp_r.next_offset);
        if (m_axis_tdata[43:32] != exp_r.raw_entry)
          report("raw_entry", 32'(m_axis_tdata[43:32]), 32'(exp_r.raw_entry));
        if (m_axis_tdata[46:44] != exp_r.status)
          report("status", 32'(m_axis_tdata[46:44]), 32'(exp_r.status));
      end
    end
  end

  initial begin
    root_reg = 32'd0;
    data_reg = 32'd0;
    clus_reg = 17'd512;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_table();
    test_directed();
    test_settings();
    drain();
    if (n_errors == 0) $display("fat12_next_cluster_lookup verification clean");
    else $display("fat12_next_cluster_lookup verification failed");
    $finish;
  end

  initial begin
    #1000000;
    $display("fat12_next_cluster_lookup verification failed");
    $finish;
  end

endmodule
